// ----- hdl/prw_pkg.sv -----
// ----------------------------------------------------------------------------
// prw_pkg: shared definitions of the reordering window
// Widths, result kinds, engine states and the structs passed between the
// input queue, the reorder engine and the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package prw_pkg;

  // Sequence number width and the pointer width, one bit wider so that a
  // pointer can sit at the end of the number space.
  localparam int SN_BITS    = 18;
  localparam int PTR_BITS   = SN_BITS + 1;

  // Window of the circular received map; the slot is the low bits of a
  // number, so the window is a power of two.
  localparam int WINDOW     = 32;
  localparam int SLOT_BITS  = $clog2(WINDOW);

  // Reordering timer limit register.
  localparam int LIMIT_BITS = 8;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(4);

  // Stream data widths, rounded up to whole bytes.
  localparam int TDATA_BITS = ((SN_BITS + 7) / 8) * 8;

  // Kind of one result word.
  typedef enum logic [1:0] {
    KIND_ACCEPTED  = 2'd0,
    KIND_OLD       = 2'd1,
    KIND_BEYOND    = 2'd2,
    KIND_DELIVERED = 2'd3
  } kind_t;

  // Engine sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_TIMER,
    ST_SKIP,
    ST_RUN2,
    ST_FLUSH
  } eng_state_t;

  // One result word.
  typedef struct packed {
    kind_t              kind;
    logic [SN_BITS-1:0] seq;
    logic               last;
  } result_t;

  // Head of the input queue, already classified.
  typedef struct packed {
    logic               valid;
    logic [SN_BITS-1:0] seq;
    kind_t              kind;
  } head_t;

  // Engine state the classifier needs.
  typedef struct packed {
    logic [PTR_BITS-1:0] deliver_ptr;
    logic [WINDOW-1:0]   received_map;
  } view_t;

endpackage

`default_nettype wire

// ----- hdl/prw_front.sv -----
// ----------------------------------------------------------------------------
// prw_front: input queue and classifier
// Holds up to two received sequence numbers and classifies the head one
// against the current window as accepted, old or duplicate, or beyond window.
// ----------------------------------------------------------------------------
`default_nettype none

module prw_front
  import prw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [SN_BITS-1:0] in_seq,
  input  wire view_t              view,
  input  wire logic               pop,
  output head_t                   head
);

  logic [SN_BITS-1:0] entries [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;
  logic               take;

  logic [SN_BITS-1:0]  seq;
  logic [PTR_BITS:0]   seq_ext;
  logic [PTR_BITS:0]   dp_ext;
  logic [PTR_BITS:0]   top;
  logic                below;
  logic                beyond;
  logic                dup;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign take     = pop && (count != 2'd0);

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, take};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_seq;
    end
  end

  // Classify the head word against the window [deliver_ptr, deliver_ptr + WINDOW).
  always_comb begin
    seq     = entries[rd_ptr];
    seq_ext = (PTR_BITS + 1)'(seq);
    dp_ext  = {1'b0, view.deliver_ptr};
    top     = dp_ext + (PTR_BITS + 1)'(WINDOW);
    below   = (seq_ext < dp_ext);
    beyond  = (seq_ext >= top);
    dup     = view.received_map[seq[SLOT_BITS-1:0]];

    head.valid = (count != 2'd0);
    head.seq   = seq;
    if (below || (!beyond && dup)) begin
      head.kind = KIND_OLD;
    end else if (beyond) begin
      head.kind = KIND_BEYOND;
    end else begin
      head.kind = KIND_ACCEPTED;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/prw_engine.sv -----
// ----------------------------------------------------------------------------
// prw_engine: reorder state and delivery sequencer
// Owns the received map, the pointers and the reordering timer. Takes one
// classified word, then walks deliveries one number per cycle when res_ready
// is high, holding the newest result so that the final one can be marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module prw_engine
  import prw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [LIMIT_BITS-1:0] cfg_wdata,
  input  wire head_t                 head,
  output logic                       pop,
  output view_t                      view,
  output logic                       res_valid,
  output result_t                    res,
  input  wire logic                  res_ready
);

  eng_state_t              state, state_next;
  logic [PTR_BITS-1:0]     deliver_ptr, deliver_ptr_next;
  logic [PTR_BITS-1:0]     next_expected, next_expected_next;
  logic [PTR_BITS-1:0]     reorder_mark, reorder_mark_next;
  logic [LIMIT_BITS-1:0]   reorder_count, reorder_count_next;
  logic [WINDOW-1:0]       received_map, received_map_next;
  logic [LIMIT_BITS-1:0]   reorder_limit;
  result_t                 pend, pend_next;

  logic [PTR_BITS-1:0]     seq_ext;
  logic                    dp_bit;
  logic                    run_ok;
  logic [LIMIT_BITS-1:0]   eff_limit;
  logic [LIMIT_BITS-1:0]   cnt_a;
  logic [LIMIT_BITS-1:0]   cnt_b;
  logic [LIMIT_BITS-1:0]   cnt_c;
  logic                    start;
  logic [PTR_BITS-1:0]     mark_b;
  logic                    expire;

  assign view = '{deliver_ptr: deliver_ptr, received_map: received_map};

  // Limit register; zero behaves as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      reorder_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      reorder_limit <= cfg_wdata;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      deliver_ptr   <= '0;
      next_expected <= '0;
      reorder_mark  <= '0;
      reorder_count <= '0;
      received_map  <= '0;
    end else begin
      state         <= state_next;
      deliver_ptr   <= deliver_ptr_next;
      next_expected <= next_expected_next;
      reorder_mark  <= reorder_mark_next;
      reorder_count <= reorder_count_next;
      received_map  <= received_map_next;
    end
  end

  // Pending result word.
  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

  // Timer evaluation after the in-order run of the current word.
  always_comb begin
    eff_limit = (reorder_limit == '0) ? LIMIT_BITS'(1) : reorder_limit;
    cnt_a     = (reorder_count != '0 && deliver_ptr >= reorder_mark) ? '0 : reorder_count;
    cnt_b     = (cnt_a != '0) ? cnt_a + LIMIT_BITS'(1) : '0;
    start     = (cnt_b == '0) && (deliver_ptr < next_expected);
    mark_b    = start ? next_expected : reorder_mark;
    cnt_c     = start ? LIMIT_BITS'(1) : cnt_b;
    expire    = (cnt_c != '0) && (cnt_c >= eff_limit);
  end

  // Sequencer: next state and outputs.
  always_comb begin
    state_next         = state;
    deliver_ptr_next   = deliver_ptr;
    next_expected_next = next_expected;
    reorder_mark_next  = reorder_mark;
    reorder_count_next = reorder_count;
    received_map_next  = received_map;
    pend_next          = pend;
    pop                = 1'b0;
    res_valid          = 1'b0;
    res                = pend;
    res.last           = 1'b0;

    seq_ext = PTR_BITS'(head.seq);
    dp_bit  = received_map[deliver_ptr[SLOT_BITS-1:0]];
    run_ok  = (deliver_ptr < next_expected) && dp_bit;

    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop            = 1'b1;
          pend_next.kind = head.kind;
          pend_next.seq  = head.seq;
          pend_next.last = 1'b0;
          state_next     = ST_TIMER;
          if (head.kind == KIND_ACCEPTED) begin
            received_map_next[head.seq[SLOT_BITS-1:0]] = 1'b1;
            if (seq_ext >= next_expected) begin
              next_expected_next = seq_ext + PTR_BITS'(1);
            end
            if (seq_ext == deliver_ptr) begin
              state_next = ST_RUN;
            end
          end
        end
      end

      // In-order run after an accepted word, and again after a skip.
      ST_RUN, ST_RUN2: begin
        if (run_ok) begin
          if (res_ready) begin
            res_valid      = 1'b1;
            pend_next.kind = KIND_DELIVERED;
            pend_next.seq  = deliver_ptr[SN_BITS-1:0];
            pend_next.last = 1'b0;
            received_map_next[deliver_ptr[SLOT_BITS-1:0]] = 1'b0;
            deliver_ptr_next = deliver_ptr + PTR_BITS'(1);
          end
        end else if (state == ST_RUN) begin
          state_next = ST_TIMER;
        end else begin
          reorder_count_next = '0;
          reorder_mark_next  = next_expected;
          state_next         = ST_FLUSH;
        end
      end

      ST_TIMER: begin
        if (expire) begin
          reorder_mark_next = mark_b;
          state_next        = ST_SKIP;
        end else begin
          reorder_count_next = cnt_c;
          reorder_mark_next  = (cnt_c == '0) ? next_expected : mark_b;
          if (res_ready) begin
            res_valid  = 1'b1;
            res.last   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_FLUSH;
          end
        end
      end

      // Timer expired: deliver what is held below the mark, step over gaps.
      ST_SKIP: begin
        if (deliver_ptr < reorder_mark) begin
          if (dp_bit) begin
            if (res_ready) begin
              res_valid      = 1'b1;
              pend_next.kind = KIND_DELIVERED;
              pend_next.seq  = deliver_ptr[SN_BITS-1:0];
              pend_next.last = 1'b0;
              received_map_next[deliver_ptr[SLOT_BITS-1:0]] = 1'b0;
              deliver_ptr_next = deliver_ptr + PTR_BITS'(1);
            end
          end else begin
            deliver_ptr_next = deliver_ptr + PTR_BITS'(1);
          end
        end else begin
          state_next = ST_RUN2;
        end
      end

      ST_FLUSH: begin
        if (res_ready) begin
          res_valid  = 1'b1;
          res.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/prw_out_queue.sv -----
// ----------------------------------------------------------------------------
// prw_out_queue: two-word result queue
// Registers result words between the engine and the output stream so that
// the engine need not wait on the consumer from one cycle to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module prw_out_queue
  import prw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire result_t in_word,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_word
);

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_word  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign take      = out_valid && out_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, take};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_word;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pdcp_reorder_window.sv -----
// ----------------------------------------------------------------------------
// pdcp_reorder_window: receive-side reordering window
// The engine takes a number from the head of the input queue and holds its
// first result word as pending; the word then enters the result queue, which
// registers it for the stream. On a timer expiry it goes out later, with the
// first delivered number of the skip or at the end of it. The engine's single
// delivery sequencer handles one number at a time and takes the next only
// after the last word of the one before; an in-order run, the walk over the
// slots up to the mark on an expiry (at most WINDOW) and output stalls delay it.
// Reset (rst, synchronous): pointers, timer and received map clear, both
// queues empty, reorder_limit returns to 4.
// ----------------------------------------------------------------------------
`default_nettype none

module pdcp_reorder_window
  import prw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Limit register write.
  input  wire logic                  cfg_we,
  input  wire logic [LIMIT_BITS-1:0] cfg_wdata,
  // Received numbers.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [TDATA_BITS-1:0] s_axis_tdata,   // [SN_BITS-1:0] seq_num, rest zero
  // Result words.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [TDATA_BITS-1:0]      m_axis_tdata,   // [SN_BITS-1:0] out_seq, rest zero
  output logic [1:0]                 m_axis_tuser,   // [1:0] kind
  output logic                       m_axis_tlast    // last
);

  head_t   head;
  view_t   view;
  logic    pop;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_word;

  // Input queue and classifier.
  prw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_seq   (s_axis_tdata[SN_BITS-1:0]),
    .view     (view),
    .pop      (pop),
    .head     (head)
  );

  // Reorder state and delivery sequencer.
  prw_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .view      (view),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Result queue towards the output stream.
  prw_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_word   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  // Pack the result word onto the stream.
  assign m_axis_tdata = TDATA_BITS'(out_word.seq);
  assign m_axis_tuser = out_word.kind;
  assign m_axis_tlast = out_word.last;

endmodule

`default_nettype wire

// ----- test/tb_pdcp_reorder_window.sv -----
// ----------------------------------------------------------------------------
// tb_pdcp_reorder_window: self-checking bench of the reordering window
// Received sequence numbers go in on the slave stream. A predictor written
// against the block's specification tracks the window, the received map and
// the arrival-driven reordering timer, and queues the words it expects. A
// monitor compares every result word, field by field, in order. Stimulus
// runs a directed part, then random phases of reordered bursts with losses
// and duplicates mixed with noise under several limit settings, then numbers
// from anywhere in the sequence number space. Both streams idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pdcp_reorder_window;
  import prw_pkg::*;

  localparam int unsigned SN_TOP = 1 << SN_BITS;

  logic                  clk;
  logic                  rst           = 1'b1;
  logic                  cfg_we        = 1'b0;
  logic [LIMIT_BITS-1:0] cfg_wdata     = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_BITS-1:0] s_axis_tdata  = '0;   // [SN_BITS-1:0] seq_num, rest zero
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_axis_tdata;          // [SN_BITS-1:0] out_seq, rest zero
  logic [1:0]            m_axis_tuser;          // [1:0] kind
  logic                  m_axis_tlast;

  pdcp_reorder_window DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Numbers waiting to be sent and words still expected from the block.
  logic [SN_BITS-1:0] arrivals_pending[$];
  result_t            awaited_words[$];
  int unsigned        mismatches = 0;
  bit                 quiet      = 1'b0;
  int unsigned        send_gap   = 0;
  int unsigned        recv_gap   = 0;

  // Predicted window state, as the block holds it after reset.
  int unsigned           win_ptr     = 0;
  int unsigned           high_mark   = 0;
  int unsigned           skip_mark   = 0;
  int unsigned           tick_count  = 0;
  logic [WINDOW-1:0]     rx_map      = '0;
  logic [LIMIT_BITS-1:0] reorder_lim = LIMIT_RESET;

  // Words produced by the arrival being predicted.
  kind_t       step_kind[$];
  int unsigned step_seq[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb_pdcp_reorder_window failed");
    $finish;
  end

  // Mostly back to back, sometimes a short pause, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic note_word(kind_t k, int unsigned n);
    step_kind.push_back(k);
    step_seq.push_back(n);
  endtask

  // Deliver the contiguous received run starting at the delivery pointer.
  task automatic release_run();
    while (win_ptr < high_mark && rx_map[win_ptr % WINDOW]) begin
      note_word(KIND_DELIVERED, win_ptr);
      rx_map[win_ptr % WINDOW] = 1'b0;
      win_ptr++;
    end
  endtask

  // Classify one arrival, step the timer and queue every word it causes.
  task automatic track_arrival(logic [SN_BITS-1:0] sn);
    int unsigned r;
    int unsigned top;
    int unsigned lim;
    int unsigned p;
    result_t     w;
    r   = sn;
    top = win_ptr + WINDOW;
    lim = (reorder_lim == 0) ? 1 : reorder_lim;
    step_kind.delete();
    step_seq.delete();

    if (r < win_ptr || (r < top && rx_map[r % WINDOW])) begin
      note_word(KIND_OLD, r);
    end else if (r >= top) begin
      note_word(KIND_BEYOND, r);
    end else begin
      rx_map[r % WINDOW] = 1'b1;
      note_word(KIND_ACCEPTED, r);
      if (r >= high_mark) high_mark = r + 1;
      if (r == win_ptr) release_run();
    end

    // The timer counts arrivals; it stops once delivery has reached the mark.
    if (tick_count != 0 && win_ptr >= skip_mark) tick_count = 0;
    if (tick_count != 0) tick_count++;
    if (tick_count == 0 && win_ptr < high_mark) begin
      skip_mark  = high_mark;
      tick_count = 1;
    end
    // On expiry, release what arrived below the mark and skip the holes.
    if (tick_count != 0 && tick_count >= lim) begin
      for (p = win_ptr; p < skip_mark; p++) begin
        if (rx_map[p % WINDOW]) begin
          note_word(KIND_DELIVERED, p);
          rx_map[p % WINDOW] = 1'b0;
        end
      end
      if (skip_mark > win_ptr) win_ptr = skip_mark;
      release_run();
      tick_count = 0;
    end
    if (tick_count == 0) skip_mark = high_mark;

    for (int i = 0; i < step_kind.size(); i++) begin
      w.kind = step_kind[i];
      w.seq  = SN_BITS'(step_seq[i]);
      w.last = (i == step_kind.size() - 1);
      awaited_words.push_back(w);
    end
  endtask

  // Sender: predict each accepted number, then offer the next after a gap.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_arrival(s_axis_tdata[SN_BITS-1:0]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (arrivals_pending.size() != 0) begin
          s_axis_tdata  <= {{(TDATA_BITS-SN_BITS){1'b0}}, arrivals_pending.pop_front()};
          s_axis_tvalid <= 1'b1;
          send_gap = quiet ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result word against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d seq %0d last %0b",
                                    m_axis_tuser, m_axis_tdata, m_axis_tlast));
        end else begin
          want = awaited_words.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch($sformatf("seq %0d: kind %0d, expected %0d",
                                      want.seq, m_axis_tuser, want.kind));
          if (m_axis_tdata !== {{(TDATA_BITS-SN_BITS){1'b0}}, want.seq})
            report_mismatch($sformatf("data %0h, expected seq %0h", m_axis_tdata, want.seq));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("seq %0d: last %0b, expected %0b",
                                      want.seq, m_axis_tlast, want.last));
        end
        recv_gap = quiet ? 0 : pick_gap();
      end else if (recv_gap != 0) begin
        recv_gap--;
      end
      m_axis_tready <= (recv_gap == 0);
    end
  end

  // Wait until every number is taken and every word is back, then let the
  // engine finish any skip walk it may still be on.
  task automatic drain();
    do @(negedge clk);
    while (arrivals_pending.size() != 0 || s_axis_tvalid || awaited_words.size() != 0);
    repeat (2 * WINDOW + 8) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_BITS-1:0] v);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    reorder_lim = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send(int unsigned n);
    arrivals_pending.push_back(SN_BITS'(n));
  endtask

  // Mostly reordered bursts with losses and duplicates, some noise.
  task automatic random_phase(int unsigned count);
    int unsigned stream;
    int unsigned roll;
    int unsigned len;
    int unsigned j;
    int unsigned tmp;
    int unsigned burst[$];
    stream = win_ptr;
    while (count != 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        len = $urandom_range(2, 12);
        burst.delete();
        for (int k = 0; k < len; k++)
          if ($urandom_range(0, 9) != 0) burst.push_back(stream + k);
        for (int k = 1; k < burst.size(); k++) begin
          if ($urandom_range(0, 2) == 0) begin
            j        = $urandom_range(0, k);
            tmp      = burst[k];
            burst[k] = burst[j];
            burst[j] = tmp;
          end
        end
        if (burst.size() != 0 && $urandom_range(0, 4) == 0)
          burst.push_back(burst[$urandom_range(0, burst.size() - 1)]);
        foreach (burst[k]) begin
          if (count != 0) begin
            send(burst[k]);
            count--;
          end
        end
        stream += len;
      end else begin
        if (roll < 85) send($urandom_range(0, SN_TOP - 1));
        else if (roll < 93) send(stream > 40 ? stream - $urandom_range(1, 40) : 0);
        else send(stream + $urandom_range(WINDOW, 200));
        count--;
      end
    end
  endtask

  initial begin
    int unsigned base;
    int unsigned phase_limit[6];

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: first delivery, old, duplicate, window edges, widest number.
    send(0); send(0); send(2); send(2); send(33); send(32);
    send(SN_TOP - 1); send(5); send(1); send(7);

    // A zero limit behaves as one.
    write_limit(LIMIT_BITS'(0));
    base = win_ptr;
    send(base + 1); send(base + WINDOW - 1); send(base); send(base + WINDOW);

    // Timer running at the highest limit, then the limit lowered under it.
    write_limit(LIMIT_BITS'(255));
    base = win_ptr;
    for (int k = 1; k <= 5; k++) send(base + k);
    write_limit(LIMIT_BITS'(2));
    send(base + 6);

    // Random phases; each pauses half way until all words have come back.
    phase_limit = '{1, 3, 8, 255, 4, 0};
    phase_limit[5] = $urandom_range(1, 254);
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(LIMIT_BITS'(phase_limit[ph]));
      quiet = (ph == 2);
      random_phase(27);
      drain();
      random_phase(27);
    end

    // Flush the timer with a limit of one using the widest number.
    write_limit(LIMIT_BITS'(1));
    quiet = 1'b1;
    send(SN_TOP - 1);
    send(SN_TOP - 1);
    drain();

    // Numbers from anywhere in the space under a random limit.
    write_limit(LIMIT_BITS'($urandom_range(1, 255)));
    quiet = 1'b0;
    send(0);
    send(SN_TOP - 1);
    send(SN_TOP / 2);
    for (int k = 0; k < 5; k++) send($urandom_range(0, SN_TOP - 1));
    drain();

    if (mismatches == 0) begin
      $display("tb_pdcp_reorder_window passed");
    end else begin
      $display("tb_pdcp_reorder_window failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/prw_pkg.sv
hdl/prw_front.sv
hdl/prw_engine.sv
hdl/prw_out_queue.sv
hdl/pdcp_reorder_window.sv
test/tb_pdcp_reorder_window.sv
